>>> design/pnce_pkg.sv
// shared types and constants for the palette nearest color engine
// no dependencies; imported by every module of the block

package pnce_pkg;

    // palette geometry
    localparam int PNCE_MAX_ENTRIES = 256;
    localparam int PNCE_WORD_W      = 32;

    // palette_bits register
    localparam int             BITS_W       = 4;
    localparam logic [BITS_W-1:0] PAL_BITS_RST = 4'd8;
    localparam logic [BITS_W-1:0] PAL_BITS_MIN = 4'd1;
    localparam logic [BITS_W-1:0] PAL_BITS_MAX = 4'd8;

    // width of 2^palette_bits, up to 256
    localparam int POW_W = 9;

    // squared rgb distance, at most 3 * 255^2
    localparam int SQ_W   = 16;
    localparam int DIST_W = 18;

    localparam logic [7:0]             ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]             CHAN_ZERO    = 8'h00;
    localparam logic [PNCE_WORD_W-1:0] OPAQUE_BLACK = 32'hFF00_0000;

    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_READ   = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_RAMP   = 2'd3
    } pnce_mode_t;

    typedef struct packed {
        pnce_mode_t mode;
        logic [7:0] entry_index;
        logic [7:0] in_alpha;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } pnce_req_t;

    typedef struct packed {
        logic [7:0] out_index;
        logic [7:0] out_alpha;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } pnce_rsp_t;

    // controller to datapath
    typedef struct packed {
        logic latch_req;
        logic wr_req;
        logic ramp_start;
        logic ramp_step;
        logic scan_start;
        logic scan_step;
        logic load_out;
        logic out_search;
    } pnce_cmd_t;

    // datapath to controller
    typedef struct packed {
        pnce_mode_t req_mode;
        logic       ramp_last;
        logic       scan_last;
        logic       pipe_busy;
        logic       out_free;
    } pnce_status_t;

endpackage

>>> design/pnce_ram.sv
// generic simple dual-port ram, one write and one registered read port
// depends on pnce_pkg for default sizes

module pnce_ram
    import pnce_pkg::*;
#(
    parameter int WIDTH = PNCE_WORD_W,
    parameter int DEPTH = PNCE_MAX_ENTRIES
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/pnce_ctrl.sv
// sequencer for the palette engine: request decode, ramp, read and search
// depends on pnce_pkg for command and status structs

module pnce_ctrl
    import pnce_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    input  pnce_status_t status,
    output pnce_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_RAMP,
        S_IDLE,
        S_READ,
        S_READ_OUT,
        S_SCAN,
        S_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   accept;

    assign accept    = req_valid && ready_reg;
    assign req_ready = ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_RAMP:
            begin
                cmd.ramp_step = 1'b1;
                if (status.ramp_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.latch_req = 1'b1;
                    case (status.req_mode)
                        MODE_WRITE:
                        begin
                            cmd.wr_req = 1'b1;
                        end
                        MODE_READ:
                        begin
                            state_next = S_READ;
                        end
                        MODE_SEARCH:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                        MODE_RAMP:
                        begin
                            cmd.ramp_start = 1'b1;
                            state_next     = S_RAMP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_READ_OUT;
            end
            S_READ_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!status.pipe_busy && status.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_search = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RAMP;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

endmodule

>>> design/pnce_datapath.sv
// palette datapath: config register, palette ram, ramp generator,
// distance pipeline, best tracker and response register; uses pnce_pkg and pnce_ram

module pnce_datapath
    import pnce_pkg::*;
#(
    parameter int MAX_ENTRIES = PNCE_MAX_ENTRIES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pnce_req_t         req_data,
    input  logic              cfg_valid,
    input  logic [BITS_W-1:0] cfg_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output pnce_rsp_t         rsp_data,
    input  pnce_cmd_t         cmd,
    output pnce_status_t      status
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int RW = AW + 1;
    localparam logic [CW-1:0] CAP_N  = CW'(MAX_ENTRIES);
    localparam logic [7:0]    CAP_QI = 8'(255 / MAX_ENTRIES);
    localparam logic [AW-1:0] CAP_RI = AW'(255 % MAX_ENTRIES);

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    // config and live count
    logic [BITS_W-1:0] pal_bits_reg;
    logic [BITS_W-1:0] bits_eff;
    logic [POW_W-1:0]  pow;
    logic              capped;
    logic [CW-1:0]     live_n;
    logic [CW-1:0]     live_last;
    logic [7:0]        qinc_cur;
    logic [AW-1:0]     rinc_cur;
    logic              in_range_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_bits_reg <= PAL_BITS_RST;
        end
        else if (cfg_valid)
        begin
            pal_bits_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (pal_bits_reg < PAL_BITS_MIN)
        begin
            bits_eff = PAL_BITS_MIN;
        end
        else if (pal_bits_reg > PAL_BITS_MAX)
        begin
            bits_eff = PAL_BITS_MAX;
        end
        else
        begin
            bits_eff = pal_bits_reg;
        end
        pow          = POW_W'(1) << bits_eff;
        capped       = pow > POW_W'(MAX_ENTRIES);
        live_n       = capped ? CAP_N : CW'(pow);
        live_last    = live_n - CW'(1);
        qinc_cur     = capped ? CAP_QI : (8'hFF >> bits_eff);
        rinc_cur     = capped ? CAP_RI : AW'(pow - POW_W'(1));
        in_range_now = POW_W'(req_data.entry_index) < POW_W'(live_n);
    end

    // latched request
    logic [7:0] req_idx_reg;
    logic [7:0] req_red_reg;
    logic [7:0] req_green_reg;
    logic [7:0] req_blue_reg;
    logic       req_in_range_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_idx_reg      <= req_data.entry_index;
            req_red_reg      <= req_data.in_red;
            req_green_reg    <= req_data.in_green;
            req_blue_reg     <= req_data.in_blue;
            req_in_range_reg <= in_range_now;
        end
    end

    // gray ramp: q and r track floor(i*255/n) and its remainder
    logic [CW-1:0] ramp_n_reg;
    logic [7:0]    ramp_qinc_reg;
    logic [AW-1:0] ramp_rinc_reg;
    logic [AW-1:0] ramp_idx_reg;
    logic [7:0]    ramp_q_reg;
    logic [AW-1:0] ramp_r_reg;
    logic [RW-1:0] r_sum;
    logic          r_wrap;
    logic [AW-1:0] ramp_r_next;
    logic [7:0]    ramp_q_next;

    always_comb
    begin
        r_sum       = RW'(ramp_r_reg) + RW'(ramp_rinc_reg);
        r_wrap      = r_sum >= RW'(ramp_n_reg);
        ramp_r_next = r_wrap ? AW'(r_sum - RW'(ramp_n_reg)) : AW'(r_sum);
        ramp_q_next = ramp_q_reg + ramp_qinc_reg + {7'd0, r_wrap};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_n_reg    <= CAP_N;
            ramp_qinc_reg <= CAP_QI;
            ramp_rinc_reg <= CAP_RI;
            ramp_idx_reg  <= '0;
            ramp_q_reg    <= '0;
            ramp_r_reg    <= '0;
        end
        else if (cmd.ramp_start)
        begin
            ramp_n_reg    <= live_n;
            ramp_qinc_reg <= qinc_cur;
            ramp_rinc_reg <= rinc_cur;
            ramp_idx_reg  <= '0;
            ramp_q_reg    <= '0;
            ramp_r_reg    <= '0;
        end
        else if (cmd.ramp_step)
        begin
            ramp_idx_reg <= ramp_idx_reg + AW'(1);
            ramp_q_reg   <= ramp_q_next;
            ramp_r_reg   <= ramp_r_next;
        end
    end

    // palette memory
    logic                   ram_wr_en;
    logic [AW-1:0]          ram_wr_addr;
    logic [PNCE_WORD_W-1:0] ram_wr_data;
    logic [AW-1:0]          ram_rd_addr;
    logic [PNCE_WORD_W-1:0] ram_rd_data;
    logic [AW-1:0]          scan_idx_reg;

    always_comb
    begin
        if (cmd.ramp_step)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ramp_idx_reg;
            ram_wr_data = {ALPHA_OPAQUE, ramp_q_reg, ramp_q_reg, ramp_q_reg};
        end
        else
        begin
            ram_wr_en   = cmd.wr_req && in_range_now;
            ram_wr_addr = req_data.entry_index[AW-1:0];
            ram_wr_data = {req_data.in_alpha, req_data.in_red, req_data.in_green,
                           req_data.in_blue};
        end
        ram_rd_addr = cmd.scan_step ? scan_idx_reg : req_idx_reg[AW-1:0];
    end

    pnce_ram #(
        .WIDTH (PNCE_WORD_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // scan address counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.scan_start)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + AW'(1);
        end
    end

    // distance pipeline: ram data, squares, then sum and compare
    logic            rd_vld_reg;
    logic [AW-1:0]   rd_idx_reg;
    logic            sq_vld_reg;
    logic [AW-1:0]   sq_idx_reg;
    logic [SQ_W-1:0] sq_red_reg;
    logic [SQ_W-1:0] sq_green_reg;
    logic [SQ_W-1:0] sq_blue_reg;
    logic [7:0]      d_red;
    logic [7:0]      d_green;
    logic [7:0]      d_blue;
    logic [DIST_W-1:0] sum_sq;
    logic [DIST_W-1:0] best_dist_reg;
    logic [AW-1:0]     best_idx_reg;

    always_comb
    begin
        d_red   = abs_diff(ram_rd_data[23:16], req_red_reg);
        d_green = abs_diff(ram_rd_data[15:8], req_green_reg);
        d_blue  = abs_diff(ram_rd_data[7:0], req_blue_reg);
        sum_sq  = DIST_W'(sq_red_reg) + DIST_W'(sq_green_reg) + DIST_W'(sq_blue_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            sq_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan_step;
            sq_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= scan_idx_reg;
        sq_idx_reg   <= rd_idx_reg;
        sq_red_reg   <= SQ_W'(d_red * d_red);
        sq_green_reg <= SQ_W'(d_green * d_green);
        sq_blue_reg  <= SQ_W'(d_blue * d_blue);
        if (cmd.scan_start)
        begin
            best_dist_reg <= '1;
            best_idx_reg  <= '0;
        end
        else if (sq_vld_reg && (sum_sq < best_dist_reg))
        begin
            // strict compare keeps the lowest index on ties
            best_dist_reg <= sum_sq;
            best_idx_reg  <= sq_idx_reg;
        end
    end

    // response register
    logic                   rsp_valid_reg;
    pnce_rsp_t              rsp_reg;
    logic [PNCE_WORD_W-1:0] rd_word;

    assign rd_word = req_in_range_reg ? ram_rd_data : OPAQUE_BLACK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (cmd.out_search)
            begin
                rsp_reg <= {8'(best_idx_reg), CHAN_ZERO, CHAN_ZERO, CHAN_ZERO, CHAN_ZERO};
            end
            else
            begin
                rsp_reg <= {req_idx_reg, rd_word};
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    assign status.req_mode  = req_data.mode;
    assign status.ramp_last = CW'(ramp_idx_reg) == (ramp_n_reg - CW'(1));
    assign status.scan_last = CW'(scan_idx_reg) == live_last;
    assign status.pipe_busy = rd_vld_reg || sq_vld_reg;
    assign status.out_free  = !rsp_valid_reg || rsp_ready;

endmodule

>>> design/palette_nearest_color_engine.sv
// top level of the palette nearest color engine
// depends on pnce_pkg, pnce_ctrl, pnce_datapath and pnce_ram

// The engine holds an ARGB palette of MAX_ENTRIES words in one ram, of which
// the first n = min(2^palette_bits, MAX_ENTRIES) are live (palette_bits is
// clamped to 1..8). After reset the engine writes the gray ramp over all
// MAX_ENTRIES entries, one per cycle, with req_ready low; config writes are
// taken during that pass. Per request: a write is done on acceptance, a read
// passes S_READ and S_READ_OUT, a ramp reload does one ram write per live
// entry, and a nearest search has the single ram read port visit each live
// entry once, followed by a two-stage square and compare pipeline; a read or
// search waits in S_READ_OUT or S_DRAIN while the response register is full.
// Only one request is in progress at a time; the response register lets the
// next request start while a response waits on rsp_ready.

module palette_nearest_color_engine
    import pnce_pkg::*;
#(
    parameter int MAX_ENTRIES = PNCE_MAX_ENTRIES
) (
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              req_valid,
    output logic              req_ready,
    input  pnce_req_t         req_data,
    // response channel
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output pnce_rsp_t         rsp_data,
    // palette_bits write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [BITS_W-1:0] cfg_data
);

    pnce_cmd_t    cmd;
    pnce_status_t status;

    // the register write is always taken
    assign cfg_ready = 1'b1;

    // sequencer: decodes the request mode and walks ramp, read and scan
    pnce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // palette ram, ramp generator, distance pipeline and response register
    pnce_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> design/pnce_checker.sv
// port-level checks for the palette nearest color engine, bound to the top
// depends on pnce_pkg and palette_nearest_color_engine

module pnce_checker
    import pnce_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input pnce_req_t req_data,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input pnce_rsp_t rsp_data
);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response dropped or changed while stalled");

    // a write finishes in its own cycle, so the engine stays open
    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_data.mode == MODE_WRITE) |=> req_ready)
        else $error("engine busy after a palette write");

    // read, search and ramp requests leave the engine busy right after acceptance
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_data.mode != MODE_WRITE) |=> !req_ready)
        else $error("engine open again right after a multi-cycle request");

    // a new response only comes out of a busy engine
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("response appeared without a request in progress");

endmodule

bind palette_nearest_color_engine pnce_checker u_pnce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);
